// ===== rtl/rmq_pkg.sv =====
// Shared constants, payload types and a helper function of the matrix-to-quaternion block.
package rmq_pkg;

   localparam int ENTRY_FRAC_BITS = 14;
   localparam int IN_W = 16;
   localparam int OUT_W = 16;
   localparam int OUT_FRAC = 14;
   localparam int MAG_W = ((ENTRY_FRAC_BITS + 3) > 18) ? (ENTRY_FRAC_BITS + 3) : 18;
   localparam int Q_W = MAG_W + 1;
   localparam int NORM_MSB = 30;
   localparam int SH_W = NORM_MSB + 1;
   localparam int K_W = $clog2(SH_W);
   localparam int SQ_W = 2 * SH_W;
   localparam int SUM_W = 64;
   localparam int ROOT_W = SUM_W / 2;
   localparam int REM_W = ROOT_W + 2;
   localparam int QUO_W = OUT_FRAC + 1;
   localparam int NUM_W = SH_W + OUT_FRAC + 1;
   localparam int OUT_ONE = 1 << OUT_FRAC;

   typedef struct packed {
      logic signed [IN_W-1:0] m00;
      logic signed [IN_W-1:0] m01;
      logic signed [IN_W-1:0] m02;
      logic signed [IN_W-1:0] m10;
      logic signed [IN_W-1:0] m11;
      logic signed [IN_W-1:0] m12;
      logic signed [IN_W-1:0] m20;
      logic signed [IN_W-1:0] m21;
      logic signed [IN_W-1:0] m22;
   } rmq_matrix_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] quat_x;
      logic signed [OUT_W-1:0] quat_y;
      logic signed [OUT_W-1:0] quat_z;
      logic signed [OUT_W-1:0] quat_w;
      logic                    invalid;
   } rmq_quat_type;

   typedef struct packed {
      logic                      invalid;
      logic [3:0]                neg;
      logic [3:0][SH_W-1:0]      mag;
   } rmq_side_type;

   typedef struct packed {
      logic                      invalid;
      logic [3:0]                neg;
      logic [3:0][QUO_W-1:0]     quo;
   } rmq_div_out_type;

   function automatic logic [K_W-1:0] norm_shift(input logic [MAG_W-1:0] v);
      logic [K_W-1:0] k;
      k = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            k = K_W'(NORM_MSB - i);
         end
      end
      return k;
   endfunction

endpackage

// ===== rtl/rmq_req_if.sv =====
// Request channel carrying one rotation matrix word.
interface rmq_req_if import rmq_pkg::*; ();
   logic           valid;
   logic           ready;
   rmq_matrix_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rmq_rsp_if.sv =====
// Response channel carrying one quaternion word.
interface rmq_rsp_if import rmq_pkg::*; ();
   logic         valid;
   logic         ready;
   rmq_quat_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/rmq_front.sv =====
// Branch selection, magnitude normalization and sum of squares stages.
module rmq_front import rmq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  rmq_matrix_type in_data,
   output logic           out_valid,
   output rmq_side_type   out_side,
   output logic [SUM_W-1:0] out_sum
);

   logic signed [Q_W-1:0] e [9];
   logic signed [Q_W-1:0] one, tr, r;
   logic signed [Q_W-1:0] q [4];
   rmq_side_type a_in;

   logic [5:0] v_ff;
   rmq_side_type a_ff, c_ff, d_ff, e_ff, f_ff;
   logic [3:0][MAG_W-1:0] a_mag_ff;
   logic [K_W-1:0] k_ff;
   rmq_side_type b_ff;
   logic [3:0][MAG_W-1:0] b_mag_ff;
   logic [3:0][SQ_W-1:0] sq_ff;
   logic [SQ_W:0] p0_ff, p1_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [MAG_W-1:0] orv;

   always_comb begin
      e[0] = Q_W'(in_data.m00);
      e[1] = Q_W'(in_data.m01);
      e[2] = Q_W'(in_data.m02);
      e[3] = Q_W'(in_data.m10);
      e[4] = Q_W'(in_data.m11);
      e[5] = Q_W'(in_data.m12);
      e[6] = Q_W'(in_data.m20);
      e[7] = Q_W'(in_data.m21);
      e[8] = Q_W'(in_data.m22);
      one = Q_W'(1) <<< ENTRY_FRAC_BITS;
      tr = e[0] + e[4] + e[8];
      if (tr > 0) begin
         r = one + tr;
         q[0] = e[7] - e[5]; q[1] = e[2] - e[6]; q[2] = e[3] - e[1]; q[3] = r;
      end else if (e[0] > e[4] && e[0] > e[8]) begin
         r = one + e[0] - e[4] - e[8];
         q[0] = r; q[1] = e[1] + e[3]; q[2] = e[2] + e[6]; q[3] = e[7] - e[5];
      end else if (e[4] > e[8]) begin
         r = one + e[4] - e[0] - e[8];
         q[0] = e[1] + e[3]; q[1] = r; q[2] = e[5] + e[7]; q[3] = e[2] - e[6];
      end else begin
         r = one + e[8] - e[0] - e[4];
         q[0] = e[2] + e[6]; q[1] = e[5] + e[7]; q[2] = r; q[3] = e[3] - e[1];
      end
      a_in = '0;
      a_in.invalid = (r <= 0);
      for (int i = 0; i < 4; i++) begin
         a_in.neg[i] = q[i][Q_W-1];
      end
   end

   always_comb begin
      orv = '0;
      for (int i = 0; i < 4; i++) begin
         orv = orv | a_mag_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         for (int i = 0; i < 4; i++) begin
            a_mag_ff[i] <= q[i][Q_W-1] ? MAG_W'(-q[i]) : MAG_W'(q[i]);
         end
         b_ff <= a_ff;
         b_mag_ff <= a_mag_ff;
         k_ff <= norm_shift(orv);
         c_ff.invalid <= b_ff.invalid;
         c_ff.neg <= b_ff.neg;
         for (int i = 0; i < 4; i++) begin
            c_ff.mag[i] <= SH_W'(b_mag_ff[i]) << k_ff;
         end
         d_ff <= c_ff;
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= SQ_W'(c_ff.mag[i]) * SQ_W'(c_ff.mag[i]);
         end
         e_ff <= d_ff;
         p0_ff <= (SQ_W + 1)'(sq_ff[0]) + (SQ_W + 1)'(sq_ff[1]);
         p1_ff <= (SQ_W + 1)'(sq_ff[2]) + (SQ_W + 1)'(sq_ff[3]);
         f_ff <= e_ff;
         sum_ff <= SUM_W'(p0_ff) + SUM_W'(p1_ff);
      end
   end

   assign out_valid = v_ff[5];
   assign out_side = f_ff;
   assign out_sum = sum_ff;

endmodule

// ===== rtl/rmq_sqrt.sv =====
// Bit-per-stage integer square root pipeline that carries the side data along.
module rmq_sqrt import rmq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rmq_side_type      in_side,
   input  logic [SUM_W-1:0]  in_sum,
   output logic              out_valid,
   output rmq_side_type      out_side,
   output logic [ROOT_W-1:0] out_root
);

   logic [ROOT_W:1]     v_ff;
   rmq_side_type        side_ff [1:ROOT_W];
   logic [SUM_W-1:0]    l_ff [1:ROOT_W];
   logic [REM_W-1:0]    rem_ff [1:ROOT_W];
   logic [ROOT_W-1:0]   root_ff [1:ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic v_cur;
      rmq_side_type side_cur;
      logic [SUM_W-1:0] l_cur;
      logic [REM_W-1:0] rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [REM_W+1:0] rem_x, trial;
      logic ge;
      if (i == 0) begin : g_head
         assign v_cur = in_valid;
         assign side_cur = in_side;
         assign l_cur = in_sum;
         assign rem_cur = '0;
         assign root_cur = '0;
      end else begin : g_link
         assign v_cur = v_ff[i];
         assign side_cur = side_ff[i];
         assign l_cur = l_ff[i];
         assign rem_cur = rem_ff[i];
         assign root_cur = root_ff[i];
      end
      always_comb begin
         rem_x = {rem_cur, l_cur[SUM_W-1 -: 2]};
         trial = {2'b00, root_cur, 2'b01};
         ge = (rem_x >= trial);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1] <= side_cur;
            l_ff[i+1] <= l_cur << 2;
            rem_ff[i+1] <= ge ? REM_W'(rem_x - trial) : REM_W'(rem_x);
            root_ff[i+1] <= {root_cur[ROOT_W-2:0], ge};
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_side = side_ff[ROOT_W];
   assign out_root = root_ff[ROOT_W];

endmodule

// ===== rtl/rmq_div.sv =====
// Four-lane restoring divider pipeline giving the rounded unit-length components.
module rmq_div import rmq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rmq_side_type      in_side,
   input  logic [ROOT_W-1:0] in_root,
   output logic              out_valid,
   output rmq_div_out_type   out_data
);

   logic [QUO_W:0]          v_ff;
   logic                    inv_ff [QUO_W+1];
   logic [3:0]              neg_ff [QUO_W+1];
   logic [ROOT_W-1:0]       len_ff [QUO_W+1];
   logic [3:0][NUM_W-1:0]   rem_ff [QUO_W+1];
   logic [3:0][QUO_W-1:0]   quo_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff[0] <= in_side.invalid;
         neg_ff[0] <= in_side.neg;
         len_ff[0] <= in_root;
         quo_ff[0] <= '0;
         for (int i = 0; i < 4; i++) begin
            rem_ff[0][i] <= (NUM_W'(in_side.mag[i]) << OUT_FRAC)
                            + NUM_W'(in_root >> 1);
         end
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [NUM_W-1:0] d;
      logic [3:0] ge;
      always_comb begin
         d = NUM_W'(len_ff[j]) << (QUO_W - 1 - j);
         for (int i = 0; i < 4; i++) begin
            ge[i] = (rem_ff[j][i] >= d);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            inv_ff[j+1] <= inv_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            len_ff[j+1] <= len_ff[j];
            for (int i = 0; i < 4; i++) begin
               rem_ff[j+1][i] <= ge[i] ? (rem_ff[j][i] - d) : rem_ff[j][i];
               quo_ff[j+1][i] <= {quo_ff[j][i][QUO_W-2:0], ge[i]};
            end
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_data.invalid = inv_ff[QUO_W];
   assign out_data.neg = neg_ff[QUO_W];
   assign out_data.quo = quo_ff[QUO_W];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Top level of the rotation matrix to unit quaternion converter.
// The request channel req_if takes one word holding the nine Q2.14 matrix
// entries, and the response channel rsp_if returns one word holding the
// Q2.14 quaternion (x, y, z, w) and an invalid flag for every request.
// A word is moved at a rising clock edge where valid and ready are both high.
// The block is a single pipeline of 55 register stages: six front stages pick
// the branch, normalize and sum the squares, 32 stages resolve the square root
// one bit each, 16 stages perform the rounded division, and one output stage
// saturates and applies the identity quaternion for an invalid radicand.
// One word may enter in every cycle while the pipeline is not held, so the
// sustained rate is one word per cycle while rsp_if.ready stays high.
// When the receiver holds rsp_if.ready low with a word waiting, the whole
// pipeline holds and req_if.ready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits, leaving the pipeline empty.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
   input  logic clock,
   input  logic reset,
   rmq_req_if.sink   req_if,
   rmq_rsp_if.source rsp_if
);

   logic en;
   logic f_valid, s_valid, d_valid;
   rmq_side_type f_side, s_side;
   logic [SUM_W-1:0] f_sum;
   logic [ROOT_W-1:0] s_root;
   rmq_div_out_type d_data;
   logic out_v_ff;
   rmq_quat_type out_ff, out_in;
   logic signed [OUT_W-1:0] comp [4];

   assign en = !out_v_ff || rsp_if.ready;
   assign req_if.ready = en;

   rmq_front u_front (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_if.valid), .in_data(req_if.data),
      .out_valid(f_valid), .out_side(f_side), .out_sum(f_sum)
   );

   rmq_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(f_valid), .in_side(f_side), .in_sum(f_sum),
      .out_valid(s_valid), .out_side(s_side), .out_root(s_root)
   );

   rmq_div u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s_valid), .in_side(s_side), .in_root(s_root),
      .out_valid(d_valid), .out_data(d_data)
   );

   always_comb begin
      logic [QUO_W-1:0] sat;
      for (int i = 0; i < 4; i++) begin
         sat = (d_data.quo[i] > QUO_W'(OUT_ONE)) ? QUO_W'(OUT_ONE) : d_data.quo[i];
         comp[i] = d_data.neg[i] ? -OUT_W'(sat) : OUT_W'(sat);
      end
      if (d_data.invalid) begin
         out_in.quat_x = '0;
         out_in.quat_y = '0;
         out_in.quat_z = '0;
         out_in.quat_w = OUT_W'(OUT_ONE);
         out_in.invalid = 1'b1;
      end else begin
         out_in.quat_x = comp[0];
         out_in.quat_y = comp[1];
         out_in.quat_z = comp[2];
         out_in.quat_w = comp[3];
         out_in.invalid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid = out_v_ff;
   assign rsp_if.data = out_ff;

endmodule
